@@ rtl/hdnl_pkg.sv @@
// Package with the types and constants shared by the Num Lock LED scanner.
`timescale 1ns / 1ps

package hdnl_pkg;

  // Walker position inside the descriptor item stream.
  typedef enum logic [1:0] {
    PH_PREFIX    = 2'd0,
    PH_DATA      = 2'd1,
    PH_LONG_SIZE = 2'd2,
    PH_LONG_SKIP = 2'd3
  } hdnl_phase_e;

  // Item types from the prefix byte.
  typedef enum logic [1:0] {
    KIND_MAIN     = 2'd0,
    KIND_GLOBAL   = 2'd1,
    KIND_LOCAL    = 2'd2,
    KIND_RESERVED = 2'd3
  } hdnl_kind_e;

  localparam logic [7:0]  LONG_ITEM_PREFIX = 8'hfe;
  localparam logic [15:0] LED_PAGE         = 16'h0008;
  localparam logic [15:0] NUMLOCK_USAGE    = 16'h0001;
  localparam logic [3:0]  MAIN_OUTPUT_TAG  = 4'h9;
  localparam logic [3:0]  GLOBAL_PAGE_TAG  = 4'h0;
  localparam logic [3:0]  LOCAL_USAGE_TAG  = 4'h0;
  localparam logic [3:0]  LOCAL_UMIN_TAG   = 4'h1;
  localparam logic [3:0]  LOCAL_UMAX_TAG   = 4'h2;
  localparam logic [1:0]  SIZE_CODE_FOUR   = 2'd3;

  // One accepted input word as seen by the walker.
  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       is_last;
  } hdnl_byte_t;

endpackage

@@ rtl/hdnl_if.sv @@
// Stream interfaces for descriptor bytes in and scan results out.
`timescale 1ns / 1ps

interface hdnl_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, req_type, data_byte, is_last, input ready);
  modport sink   (input valid, req_type, data_byte, is_last, output ready);
endinterface

interface hdnl_out_if;
  logic valid;
  logic ready;
  logic has_numlock_led;

  modport source (output valid, has_numlock_led, input ready);
  modport sink   (input valid, has_numlock_led, output ready);
endinterface

@@ rtl/hdnl_item_walker.sv @@
// Descriptor item walker: parses items and tracks usages and the Num Lock answer.
`timescale 1ns / 1ps

module hdnl_item_walker import hdnl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  hdnl_byte_t byte_i,
  output logic       answer_o
);

  hdnl_phase_e phase_q, phase_d;
  logic [2:0]  data_left_q, data_left_d;
  logic [1:0]  byte_pos_q, byte_pos_d;
  logic [8:0]  skip_left_q, skip_left_d;
  logic [2:0]  item_size_q, item_size_d;
  logic [1:0]  item_kind_q, item_kind_d;
  logic [3:0]  item_tag_q, item_tag_d;
  logic [31:0] item_data_q, item_data_d;
  logic [15:0] usage_page_q, usage_page_d;
  logic        num_pending_q, num_pending_d;
  logic [15:0] range_min_q, range_min_d;
  logic [15:0] range_min_page_q, range_min_page_d;
  logic        range_open_q, range_open_d;
  logic        answer_found_q, answer_found_d;

  logic [7:0]  b;
  logic [2:0]  sz;
  logic        fin_en;
  logic [15:0] upage;
  logic [15:0] u;
  logic [31:0] shifted;

  assign b = byte_i.data_byte;

  // Item walk for one byte, followed by the item-completion update.
  always_comb begin
    phase_d          = phase_q;
    data_left_d      = data_left_q;
    byte_pos_d       = byte_pos_q;
    skip_left_d      = skip_left_q;
    item_size_d      = item_size_q;
    item_kind_d      = item_kind_q;
    item_tag_d       = item_tag_q;
    item_data_d      = item_data_q;
    usage_page_d     = usage_page_q;
    num_pending_d    = num_pending_q;
    range_min_d      = range_min_q;
    range_min_page_d = range_min_page_q;
    range_open_d     = range_open_q;
    answer_found_d   = answer_found_q;
    fin_en           = 1'b0;
    sz               = (b[1:0] == SIZE_CODE_FOUR) ? 3'd4 : {1'b0, b[1:0]};
    shifted          = {24'd0, b} << {byte_pos_q, 3'b000};

    if (!answer_found_q) begin
      case (phase_q)
        PH_PREFIX: begin
          if (b == LONG_ITEM_PREFIX) begin
            phase_d = PH_LONG_SIZE;
          end else begin
            item_size_d = sz;
            item_kind_d = b[3:2];
            item_tag_d  = b[7:4];
            item_data_d = 32'd0;
            byte_pos_d  = 2'd0;
            if (sz == 3'd0) begin
              fin_en = 1'b1;
            end else begin
              data_left_d = sz;
              phase_d     = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          item_data_d = item_data_q | shifted;
          byte_pos_d  = byte_pos_q + 2'd1;
          data_left_d = data_left_q - 3'd1;
          if (data_left_d == 3'd0) begin
            fin_en  = 1'b1;
            phase_d = PH_PREFIX;
          end
        end
        PH_LONG_SIZE: begin
          skip_left_d = {1'b0, b} + 9'd1;
          phase_d     = PH_LONG_SKIP;
        end
        PH_LONG_SKIP: begin
          skip_left_d = skip_left_q - 9'd1;
          if (skip_left_d == 9'd0) begin
            phase_d = PH_PREFIX;
          end
        end
        default: phase_d = PH_PREFIX;
      endcase
    end

    // A four-byte usage carries its own page in the upper half.
    upage = (item_size_d == 3'd4) ? item_data_d[31:16] : usage_page_q;
    u     = item_data_d[15:0];

    // Completed item: global page, local usages, or main item.
    if (fin_en) begin
      case (item_kind_d)
        KIND_GLOBAL: begin
          if (item_tag_d == GLOBAL_PAGE_TAG) begin
            usage_page_d = u;
          end
        end
        KIND_LOCAL: begin
          if (item_tag_d == LOCAL_USAGE_TAG) begin
            if (upage == LED_PAGE && u == NUMLOCK_USAGE) begin
              num_pending_d = 1'b1;
            end
          end else if (item_tag_d == LOCAL_UMIN_TAG) begin
            range_min_d      = u;
            range_min_page_d = upage;
            range_open_d     = 1'b1;
          end else if (item_tag_d == LOCAL_UMAX_TAG) begin
            if (range_open_q && range_min_page_q == LED_PAGE && upage == LED_PAGE &&
                range_min_q <= NUMLOCK_USAGE && u >= NUMLOCK_USAGE) begin
              num_pending_d = 1'b1;
            end
            range_open_d = 1'b0;
          end
        end
        KIND_MAIN: begin
          if (item_tag_d == MAIN_OUTPUT_TAG && num_pending_q) begin
            answer_found_d = 1'b1;
          end
          num_pending_d = 1'b0;
          range_open_d  = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // An absent descriptor answers one; otherwise the answer after this byte.
  assign answer_o = byte_i.req_type | answer_found_d;

  // State registers; every result returns the walker to reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_PREFIX;
      data_left_q      <= 3'd0;
      byte_pos_q       <= 2'd0;
      skip_left_q      <= 9'd0;
      item_size_q      <= 3'd0;
      item_kind_q      <= 2'd0;
      item_tag_q       <= 4'd0;
      item_data_q      <= 32'd0;
      usage_page_q     <= 16'd0;
      num_pending_q    <= 1'b0;
      range_min_q      <= 16'd0;
      range_min_page_q <= 16'd0;
      range_open_q     <= 1'b0;
      answer_found_q   <= 1'b0;
    end else if (accept_i) begin
      if (byte_i.req_type || byte_i.is_last) begin
        phase_q          <= PH_PREFIX;
        data_left_q      <= 3'd0;
        byte_pos_q       <= 2'd0;
        skip_left_q      <= 9'd0;
        item_size_q      <= 3'd0;
        item_kind_q      <= 2'd0;
        item_tag_q       <= 4'd0;
        item_data_q      <= 32'd0;
        usage_page_q     <= 16'd0;
        num_pending_q    <= 1'b0;
        range_min_q      <= 16'd0;
        range_min_page_q <= 16'd0;
        range_open_q     <= 1'b0;
        answer_found_q   <= 1'b0;
      end else begin
        phase_q          <= phase_d;
        data_left_q      <= data_left_d;
        byte_pos_q       <= byte_pos_d;
        skip_left_q      <= skip_left_d;
        item_size_q      <= item_size_d;
        item_kind_q      <= item_kind_d;
        item_tag_q       <= item_tag_d;
        item_data_q      <= item_data_d;
        usage_page_q     <= usage_page_d;
        num_pending_q    <= num_pending_d;
        range_min_q      <= range_min_d;
        range_min_page_q <= range_min_page_d;
        range_open_q     <= range_open_d;
        answer_found_q   <= answer_found_d;
      end
    end
  end

endmodule

@@ rtl/hid_descriptor_numlock_led_scanner.sv @@
// Top level of the HID report descriptor Num Lock LED scanner.
//
// The block takes a HID report descriptor one byte per input word and gives one
// result word per descriptor: has_numlock_led is 1 when an Output main item
// declares the Num Lock LED through a Usage or a Usage Minimum/Maximum range,
// and 1 at once for a word with req_type set (descriptor absent). The result
// is given for the word marked is_last, after which all scan state returns to
// reset. One byte is accepted in every clock cycle; the item walker updates its
// registers once per byte, and a result sits in one output register, so the
// result appears in the cycle after its byte is accepted. Input stalls only
// while that output register is full and not being taken.
`timescale 1ns / 1ps

module hid_descriptor_numlock_led_scanner import hdnl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  hdnl_in_if.sink    in_i,
  hdnl_out_if.source out_o
);

  hdnl_byte_t cur_byte;
  logic       in_accept;
  logic       result_due;
  logic       answer;
  logic       out_valid_q;
  logic       out_led_q;

  assign cur_byte   = '{req_type: in_i.req_type, data_byte: in_i.data_byte,
                        is_last: in_i.is_last};
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;
  assign result_due = in_i.req_type || in_i.is_last;

  hdnl_item_walker u_walker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .byte_i   (cur_byte),
    .answer_o (answer)
  );

  // Output register for the result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept && result_due) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && result_due) begin
      out_led_q <= answer;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.has_numlock_led = out_led_q;

endmodule

@@ verif/hdnl_numlock_checker.sv @@
// Scoreboard that predicts and checks the Num Lock LED scan results.
`timescale 1ns / 1ps

module hdnl_numlock_checker import hdnl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  hdnl_in_if   byte_i,
  hdnl_out_if  led_i,
  output int   fail_count_o,
  output int   pending_o
);

  // Shadow copy of the item walker and the usage tracking.
  hdnl_phase_e walk_phase;
  logic [2:0]  bytes_due;
  logic [1:0]  data_idx;
  logic [8:0]  skip_cnt;
  logic [2:0]  cur_size;
  hdnl_kind_e  cur_kind;
  logic [3:0]  cur_tag;
  logic [31:0] cur_data;
  logic [15:0] page_reg;
  logic        numlock_seen;
  logic [15:0] min_usage;
  logic [15:0] min_page;
  logic        min_open;
  logic        led_found;

  // Expected has_numlock_led values, oldest first.
  logic        led_expect_q[$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count_o = fail_count_o + 1;
  endtask

  function automatic void clear_scan();
    walk_phase   = PH_PREFIX;
    bytes_due    = '0;
    data_idx     = '0;
    skip_cnt     = '0;
    cur_size     = '0;
    cur_kind     = KIND_MAIN;
    cur_tag      = '0;
    cur_data     = '0;
    page_reg     = '0;
    numlock_seen = 1'b0;
    min_usage    = '0;
    min_page     = '0;
    min_open     = 1'b0;
    led_found    = 1'b0;
  endfunction

  // Apply a completed short item to the page and usage tracking.
  function automatic void apply_item();
    logic [15:0] upage;
    logic [15:0] usage;
    upage = (cur_size == 3'd4) ? cur_data[31:16] : page_reg;
    usage = cur_data[15:0];
    if (cur_kind == KIND_GLOBAL && cur_tag == GLOBAL_PAGE_TAG) begin
      page_reg = cur_data[15:0];
    end else if (cur_kind == KIND_LOCAL && cur_tag == LOCAL_USAGE_TAG) begin
      if (upage == LED_PAGE && usage == NUMLOCK_USAGE) numlock_seen = 1'b1;
    end else if (cur_kind == KIND_LOCAL && cur_tag == LOCAL_UMIN_TAG) begin
      min_usage = usage;
      min_page  = upage;
      min_open  = 1'b1;
    end else if (cur_kind == KIND_LOCAL && cur_tag == LOCAL_UMAX_TAG) begin
      // A range only counts when both ends sit on the LED page.
      if (min_open && min_page == LED_PAGE && upage == LED_PAGE &&
          min_usage <= NUMLOCK_USAGE && usage >= NUMLOCK_USAGE) begin
        numlock_seen = 1'b1;
      end
      min_open = 1'b0;
    end else if (cur_kind == KIND_MAIN) begin
      if (cur_tag == MAIN_OUTPUT_TAG && numlock_seen) led_found = 1'b1;
      numlock_seen = 1'b0;
      min_open     = 1'b0;
    end
  endfunction

  // Advance the shadow walker by one word and report any result it causes.
  function automatic void predict_byte(input logic req, input logic [7:0] b,
                                       input logic last, output logic got,
                                       output logic led);
    logic [2:0] sz;
    got = 1'b0;
    led = 1'b0;
    if (req) begin
      clear_scan();
      got = 1'b1;
      led = 1'b1;
      return;
    end
    if (!led_found) begin
      case (walk_phase)
        PH_PREFIX: begin
          if (b == LONG_ITEM_PREFIX) begin
            walk_phase = PH_LONG_SIZE;
          end else begin
            sz       = (b[1:0] == SIZE_CODE_FOUR) ? 3'd4 : {1'b0, b[1:0]};
            cur_size = sz;
            cur_kind = hdnl_kind_e'(b[3:2]);
            cur_tag  = b[7:4];
            cur_data = '0;
            data_idx = '0;
            if (sz == 3'd0) begin
              apply_item();
            end else begin
              bytes_due  = sz;
              walk_phase = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          cur_data  = cur_data | (32'(b) << (8 * data_idx));
          data_idx  = data_idx + 2'd1;
          bytes_due = bytes_due - 3'd1;
          if (bytes_due == 3'd0) begin
            apply_item();
            walk_phase = PH_PREFIX;
          end
        end
        PH_LONG_SIZE: begin
          skip_cnt   = 9'(b) + 9'd1;
          walk_phase = PH_LONG_SKIP;
        end
        default: begin
          skip_cnt = skip_cnt - 9'd1;
          if (skip_cnt == 9'd0) walk_phase = PH_PREFIX;
        end
      endcase
    end
    if (last) begin
      got = 1'b1;
      led = led_found;
      clear_scan();
    end
  endfunction

  // Results are checked before the word of the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin : watch_blk
    logic got_result;
    logic got_led;
    logic want_led;
    if (!rst_ni) begin
      clear_scan();
      led_expect_q.delete();
      fail_count_o = 0;
    end else begin
      if (led_i.valid && led_i.ready) begin
        if (led_expect_q.size() == 0) begin
          report_mismatch($sformatf("result word %b with no result outstanding",
                                    led_i.has_numlock_led));
        end else begin
          want_led = led_expect_q.pop_front();
          if (led_i.has_numlock_led !== want_led) begin
            report_mismatch($sformatf("has_numlock_led is %b, predicted %b",
                                      led_i.has_numlock_led, want_led));
          end
        end
      end
      if (byte_i.valid && byte_i.ready) begin
        predict_byte(byte_i.req_type, byte_i.data_byte, byte_i.is_last,
                     got_result, got_led);
        if (got_result) led_expect_q.push_back(got_led);
      end
    end
    pending_o = led_expect_q.size();
  end

endmodule

@@ verif/hid_descriptor_numlock_led_scanner_test.sv @@
// Testbench top that drives descriptor words into the Num Lock LED scanner.
`timescale 1ns / 1ps

module hid_descriptor_numlock_led_scanner_test import hdnl_pkg::*;;

  localparam int          STALL_LIMIT  = 2000;
  localparam int          PHASE_WORDS  = 410;

  logic        clk;
  logic        rst_n;
  int          fail_count;
  int          pending_results;
  int          idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned words_sent;
  logic [7:0]  desc_q[$];

  hdnl_in_if  byte_if ();
  hdnl_out_if led_if ();

  hid_descriptor_numlock_led_scanner DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (byte_if),
    .out_o  (led_if)
  );

  hdnl_numlock_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .byte_i       (byte_if),
    .led_i        (led_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The result side stalls at random while the current phase asks for it.
  always @(negedge clk) begin
    if (rst_n) led_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Abort if neither channel moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (byte_if.valid && byte_if.ready) || (led_if.valid && led_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] item_prefix(logic [3:0] tag, hdnl_kind_e kind,
                                             logic [1:0] sz_code);
    return {tag, kind, sz_code};
  endfunction

  // Append one short item with its little-endian data bytes.
  task automatic push_short(logic [3:0] tag, hdnl_kind_e kind, logic [1:0] sz_code,
                            logic [31:0] value);
    int n;
    n = (sz_code == SIZE_CODE_FOUR) ? 4 : int'(sz_code);
    desc_q.push_back(item_prefix(tag, kind, sz_code));
    for (int i = 0; i < n; i++) desc_q.push_back(value[8*i +: 8]);
  endtask

  // Append one long item: prefix, size, tag and n data bytes.
  task automatic push_long(int unsigned n);
    desc_q.push_back(LONG_ITEM_PREFIX);
    desc_q.push_back(8'(n));
    desc_q.push_back(8'($urandom));
    repeat (n) desc_q.push_back(8'($urandom));
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(logic req, logic [7:0] b, logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(negedge clk);
    end
    byte_if.valid     <= 1'b1;
    byte_if.req_type  <= req;
    byte_if.data_byte <= b;
    byte_if.is_last   <= last;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // Send the built descriptor; an absent-descriptor word goes in at abort_at.
  task automatic send_desc_q(int abort_at);
    foreach (desc_q[i]) begin
      if (i == abort_at) send_word(1'b1, 8'($urandom), 1'($urandom));
      send_word(1'b0, desc_q[i], i == desc_q.size() - 1);
    end
  endtask

  // Hold the sender until every outstanding result has been taken.
  task automatic drain_results();
    byte_if.valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
  endtask

  // Append one random item, weighted toward the ones that steer the answer.
  task automatic push_item();
    logic [1:0] code;
    code = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 15))
      0, 1: push_short(GLOBAL_PAGE_TAG, KIND_GLOBAL, 2'($urandom_range(1, 3)),
                       $urandom_range(0, 1) ? 32'(LED_PAGE) : $urandom);
      2, 3: push_short(LOCAL_USAGE_TAG, KIND_LOCAL, 2'($urandom_range(1, 2)),
                       $urandom_range(0, 1) ? 32'(NUMLOCK_USAGE) : $urandom_range(0, 3));
      4: push_short(LOCAL_USAGE_TAG, KIND_LOCAL, SIZE_CODE_FOUR,
                    $urandom_range(0, 1) ? {LED_PAGE, NUMLOCK_USAGE} : $urandom);
      5: push_short(LOCAL_UMIN_TAG, KIND_LOCAL, code,
                    {$urandom_range(0, 1) ? LED_PAGE : 16'($urandom),
                     16'($urandom_range(0, 2))});
      6: push_short(LOCAL_UMAX_TAG, KIND_LOCAL, code,
                    {$urandom_range(0, 1) ? LED_PAGE : 16'($urandom),
                     16'($urandom_range(0, 5))});
      7, 8: push_short(MAIN_OUTPUT_TAG, KIND_MAIN, code, $urandom);
      9: push_short(4'($urandom), KIND_MAIN, code, $urandom);
      10: push_long(($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 6));
      11: push_short(4'($urandom), KIND_RESERVED, code, $urandom);
      12: push_short(4'($urandom), hdnl_kind_e'($urandom_range(1, 2)), code, $urandom);
      13: desc_q.push_back(8'($urandom));
      default: begin
        // A complete LED report block: page, usage or range, then Output.
        push_short(GLOBAL_PAGE_TAG, KIND_GLOBAL, 2'd1, 32'(LED_PAGE));
        if ($urandom_range(0, 1)) begin
          push_short(LOCAL_USAGE_TAG, KIND_LOCAL, 2'd1, 32'(NUMLOCK_USAGE));
        end else begin
          push_short(LOCAL_UMIN_TAG, KIND_LOCAL, 2'd1, $urandom_range(0, 2));
          push_short(LOCAL_UMAX_TAG, KIND_LOCAL, 2'd1, $urandom_range(0, 5));
        end
        push_short(MAIN_OUTPUT_TAG, KIND_MAIN, 2'd1, 32'h2);
      end
    endcase
  endtask

  // Build one random descriptor, sometimes cut short or interrupted.
  task automatic run_descriptor();
    int cut;
    int abort_at;
    desc_q.delete();
    repeat ($urandom_range(1, 10)) push_item();
    if (desc_q.size() > 1 && $urandom_range(0, 6) == 0) begin
      cut = $urandom_range(1, desc_q.size() - 1);
      repeat (cut) void'(desc_q.pop_back());
    end
    abort_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, desc_q.size() - 1) : -1;
    send_desc_q(abort_at);
  endtask

  initial begin
    rst_n             = 1'b0;
    byte_if.valid     = 1'b0;
    byte_if.req_type  = 1'b0;
    byte_if.data_byte = '0;
    byte_if.is_last   = 1'b0;
    led_if.ready      = 1'b1;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    words_sent        = 0;
    idle_cycles       = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Absent descriptor answers at once.
    send_word(1'b1, 8'hff, 1'b1);
    // Four-byte usage carrying the LED page, then a bare Output item.
    desc_q.delete();
    push_short(LOCAL_USAGE_TAG, KIND_LOCAL, SIZE_CODE_FOUR, {LED_PAGE, NUMLOCK_USAGE});
    push_short(MAIN_OUTPUT_TAG, KIND_MAIN, 2'd0, 32'h0);
    send_desc_q(-1);
    // Long item skipped, then a usage range covering Num Lock.
    desc_q.delete();
    push_long(2);
    push_short(GLOBAL_PAGE_TAG, KIND_GLOBAL, 2'd1, 32'(LED_PAGE));
    push_short(LOCAL_UMIN_TAG, KIND_LOCAL, 2'd1, 32'h1);
    push_short(LOCAL_UMAX_TAG, KIND_LOCAL, 2'd1, 32'h3);
    push_short(MAIN_OUTPUT_TAG, KIND_MAIN, 2'd1, 32'h0);
    send_desc_q(-1);
    // Descriptor ends inside a short item, then right after a long prefix.
    send_word(1'b0, item_prefix(GLOBAL_PAGE_TAG, KIND_GLOBAL, 2'd2), 1'b1);
    send_word(1'b0, LONG_ITEM_PREFIX, 1'b1);
    // Absent descriptor arriving in the middle of a scan.
    send_word(1'b0, item_prefix(GLOBAL_PAGE_TAG, KIND_GLOBAL, 2'd1), 1'b0);
    send_word(1'b1, 8'h00, 1'b0);
    drain_results();

    // Random descriptors under each idling pattern.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      while (words_sent < 24 + (ph + 1) * PHASE_WORDS) run_descriptor();
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
